// ----- rtl/bcld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_pkg
// Shared types and constants of the button click and long-press detector.
// ----------------------------------------------------------------------------
package bcld_pkg;

    localparam int CFG_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int MARK_WIDTH      = 8;
    localparam int KIND_WIDTH      = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ACTIVE_LEVEL  = 2'd0,
        REG_DEBOUNCE_US   = 2'd1,
        REG_LONG_PRESS_US = 2'd2,
        REG_CLICK_GAP_US  = 2'd3
    } t_reg_index;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_NONE  = 2'd0,
        KIND_CLICK = 2'd1,
        KIND_LONG  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_TOUCH = 3'b010,
        PH_GAP   = 3'b100
    } t_phase;

    typedef struct packed {
        logic                 active_level;
        logic [CFG_WIDTH-1:0] debounce_us;
        logic [CFG_WIDTH-1:0] long_press_us;
        logic [CFG_WIDTH-1:0] click_gap_us;
    } t_cfg;

    localparam logic                 ACTIVE_LEVEL_RESET  = 1'b0;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_US_RESET   = 32'd100;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_US_RESET = 32'd500000;
    localparam logic [CFG_WIDTH-1:0] CLICK_GAP_US_RESET  = 32'd300000;

    localparam logic [MARK_WIDTH-1:0] LONG_MARK = 8'hFF;
    localparam logic [MARK_WIDTH-1:0] CLICK_MAX = 8'd254;

endpackage

// ----- rtl/bcld_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_in_if
// Sample tick channel: pin level, elapsed time and take-event flag.
// ----------------------------------------------------------------------------
interface bcld_in_if #(
    parameter int ELAPSED_WIDTH = 20
);
    logic                     valid;
    logic                     ready;
    logic                     pin_level;
    logic [ELAPSED_WIDTH-1:0] elapsed_us;
    logic                     take_event;

    modport source (output valid, output pin_level, output elapsed_us, output take_event,
                    input ready);
    modport sink   (input valid, input pin_level, input elapsed_us, input take_event,
                    output ready);
endinterface

// ----- rtl/bcld_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_out_if
// Result channel: event report and sample-taken flag.
// ----------------------------------------------------------------------------
interface bcld_out_if;
    logic       valid;
    logic       ready;
    logic       event_ready;
    logic [1:0] event_kind;
    logic [7:0] click_count;
    logic       sample_taken;

    modport source (output valid, output event_ready, output event_kind,
                    output click_count, output sample_taken, input ready);
    modport sink   (input valid, input event_ready, input event_kind,
                    input click_count, input sample_taken, output ready);
endinterface

// ----- rtl/bcld_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module bcld_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [bcld_pkg::CFG_INDEX_WIDTH-1:0] i_index,
    input  logic [bcld_pkg::CFG_WIDTH-1:0]       i_data,
    output bcld_pkg::t_cfg                       o_cfg
);
    import bcld_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level  <= ACTIVE_LEVEL_RESET;
            r_cfg.debounce_us   <= DEBOUNCE_US_RESET;
            r_cfg.long_press_us <= LONG_PRESS_US_RESET;
            r_cfg.click_gap_us  <= CLICK_GAP_US_RESET;
        end else if (i_we) begin
            case (t_reg_index'(i_index))
                REG_ACTIVE_LEVEL:  r_cfg.active_level  <= i_data[0];
                REG_DEBOUNCE_US:   r_cfg.debounce_us   <= i_data;
                REG_LONG_PRESS_US: r_cfg.long_press_us <= i_data;
                REG_CLICK_GAP_US:  r_cfg.click_gap_us  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bcld_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_in_reg
// Input register: holds one sample tick until the core takes it.
// ----------------------------------------------------------------------------
module bcld_in_reg #(
    parameter int ELAPSED_WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bcld_in_if.sink                  i_in_ch,
    input  logic                     i_advance,
    output logic                     o_valid,
    output logic                     o_pin_level,
    output logic [ELAPSED_WIDTH-1:0] o_elapsed_us,
    output logic                     o_take_event
);
    logic                     r_valid;
    logic                     r_pin_level;
    logic [ELAPSED_WIDTH-1:0] r_elapsed_us;
    logic                     r_take_event;
    logic                     in_beat;

    assign i_in_ch.ready = !r_valid || i_advance;
    assign in_beat       = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pin_level  <= i_in_ch.pin_level;
            r_elapsed_us <= i_in_ch.elapsed_us;
            r_take_event <= i_in_ch.take_event;
        end
    end

    assign o_valid      = r_valid;
    assign o_pin_level  = r_pin_level;
    assign o_elapsed_us = r_elapsed_us;
    assign o_take_event = r_take_event;

endmodule

// ----- rtl/bcld_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcld_core
// Debounce, long-press and multi-click state machine with result register.
// ----------------------------------------------------------------------------
module bcld_core #(
    parameter int TIME_WIDTH    = 32,
    parameter int ELAPSED_WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bcld_pkg::t_cfg           i_cfg,
    input  logic                     i_valid,
    input  logic                     i_pin_level,
    input  logic [ELAPSED_WIDTH-1:0] i_elapsed_us,
    input  logic                     i_take_event,
    output logic                     o_advance,
    bcld_out_if.source               o_out_ch
);
    import bcld_pkg::*;

    localparam int SUM_WIDTH = ((TIME_WIDTH > ELAPSED_WIDTH) ? TIME_WIDTH : ELAPSED_WIDTH) + 1;
    localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0]    a,
                                                      input logic [ELAPSED_WIDTH-1:0] b);
        logic [SUM_WIDTH-1:0] s;
        s = SUM_WIDTH'(a) + SUM_WIDTH'(b);
        if (s >= SUM_WIDTH'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return s[TIME_WIDTH-1:0];
    endfunction

    t_phase                r_phase,   n_phase;
    logic                  r_pending, n_pending;
    logic [TIME_WIDTH-1:0] r_press,   n_press;
    logic [TIME_WIDTH-1:0] r_hold,    n_hold;
    logic [MARK_WIDTH-1:0] r_mark,    n_mark;

    logic                  r_out_valid;
    logic                  r_ev_ready, n_ev_ready;
    t_kind                 r_kind,     n_kind;
    logic [MARK_WIDTH-1:0] r_count,    n_count;
    logic                  r_taken,    n_taken;

    logic                  step;
    logic                  pressed;
    logic                  take_hit;
    logic [TIME_WIDTH-1:0] press_sum;
    logic [TIME_WIDTH-1:0] hold_sum;

    assign o_advance = !r_out_valid || o_out_ch.ready;
    assign step      = i_valid && o_advance;
    assign pressed   = (i_pin_level == i_cfg.active_level);
    assign take_hit  = i_take_event && r_pending;
    assign press_sum = sat_add(r_press, i_elapsed_us);
    assign hold_sum  = sat_add(r_hold, i_elapsed_us);

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_press    = r_press;
        n_hold     = r_hold;
        n_mark     = r_mark;
        n_ev_ready = 1'b0;
        n_kind     = KIND_NONE;
        n_count    = '0;
        n_taken    = 1'b0;

        // the report looks at the state left by the previous tick
        if (take_hit) begin
            n_ev_ready = 1'b1;
            n_pending  = 1'b0;
            if (r_mark == LONG_MARK ||
                CMP_WIDTH'(r_hold) > CMP_WIDTH'(i_cfg.long_press_us)) begin
                n_kind = KIND_LONG;
            end else if (r_mark != '0) begin
                n_kind  = KIND_CLICK;
                n_count = r_mark;
            end
        end

        if (!n_pending) begin
            n_taken = 1'b1;
            case (r_phase)
                PH_IDLE: begin
                    if (pressed) begin
                        n_press = '0;
                        n_hold  = '0;
                        n_mark  = '0;
                        n_phase = PH_TOUCH;
                    end
                end
                PH_TOUCH: begin
                    if (pressed) begin
                        n_press = press_sum;
                        n_hold  = hold_sum;
                        if (CMP_WIDTH'(hold_sum) > CMP_WIDTH'(i_cfg.long_press_us)) begin
                            n_mark = LONG_MARK;
                        end
                    end else if (CMP_WIDTH'(r_press) > CMP_WIDTH'(i_cfg.debounce_us)) begin
                        if (r_mark == LONG_MARK) begin
                            n_phase   = PH_IDLE;
                            n_pending = 1'b1;
                        end else begin
                            if (r_mark < CLICK_MAX) begin
                                n_mark = r_mark + 1'b1;
                            end
                            n_press = '0;
                            n_hold  = '0;
                            n_phase = PH_GAP;
                        end
                    end else begin
                        // bounce: too short to be a press
                        n_mark  = '0;
                        n_press = '0;
                        n_hold  = '0;
                        n_phase = PH_IDLE;
                    end
                end
                PH_GAP: begin
                    if (pressed) begin
                        n_press = '0;
                        n_hold  = '0;
                        n_phase = PH_TOUCH;
                    end else begin
                        n_press = press_sum;
                        if (CMP_WIDTH'(press_sum) > CMP_WIDTH'(i_cfg.click_gap_us)) begin
                            n_phase   = PH_IDLE;
                            n_pending = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pending   <= 1'b0;
            r_press     <= '0;
            r_hold      <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_press   <= n_press;
                r_hold    <= n_hold;
                r_mark    <= n_mark;
            end
            if (o_advance) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ev_ready <= n_ev_ready;
            r_kind     <= n_kind;
            r_count    <= n_count;
            r_taken    <= n_taken;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.event_ready  = r_ev_ready;
    assign o_out_ch.event_kind   = r_kind;
    assign o_out_ch.click_count  = r_count;
    assign o_out_ch.sample_taken = r_taken;

    a_pending_ignores_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_pending && !i_take_event |=> !r_taken)
        else $error("tick taken while an event was pending");

    a_report_then_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ev_ready |-> r_taken)
        else $error("reported event but tick not taken");

    a_count_only_for_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind != KIND_CLICK |-> r_count == '0)
        else $error("click count set without click event");

    a_pending_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_phase == PH_IDLE)
        else $error("event pending outside idle phase");

endmodule

// ----- rtl/button_click_and_long_press_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_and_long_press_detector_unit
// Debounces a button pin and reports multi-click counts and long presses.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      beat contents
//  i_in_ch    in   valid/ready    pin_level, elapsed_us, take_event
//  o_out_ch   out  valid/ready    event_ready, event_kind, click_count, sample_taken
//  i_cfg_*    in   write enable   index 0..3, 32-bit data
//
//  one beat per cycle sustained while the output is not stalled; a result is registered
//  through the input register, then the state update into the result register
//  reset is synchronous and active low; the config registers return to defaults
//  a stalled output holds its result and the input register keeps one beat behind it
// ----------------------------------------------------------------------------
module button_click_and_long_press_detector_unit #(
    parameter int TIME_WIDTH    = 32,
    parameter int ELAPSED_WIDTH = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bcld_in_if.sink                              i_in_ch,
    bcld_out_if.source                           o_out_ch,
    input  logic                                 i_cfg_we,
    input  logic [bcld_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [bcld_pkg::CFG_WIDTH-1:0]       i_cfg_data
);
    import bcld_pkg::*;

    t_cfg                     cfg;
    logic                     advance;
    logic                     item_valid;
    logic                     item_pin_level;
    logic [ELAPSED_WIDTH-1:0] item_elapsed_us;
    logic                     item_take_event;

    bcld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bcld_in_reg #(
        .ELAPSED_WIDTH (ELAPSED_WIDTH)
    ) u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (i_in_ch),
        .i_advance    (advance),
        .o_valid      (item_valid),
        .o_pin_level  (item_pin_level),
        .o_elapsed_us (item_elapsed_us),
        .o_take_event (item_take_event)
    );

    bcld_core #(
        .TIME_WIDTH    (TIME_WIDTH),
        .ELAPSED_WIDTH (ELAPSED_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (item_valid),
        .i_pin_level  (item_pin_level),
        .i_elapsed_us (item_elapsed_us),
        .i_take_event (item_take_event),
        .o_advance    (advance),
        .o_out_ch     (o_out_ch)
    );

endmodule
